[rtl/matrix4x4_vector_transform_core_defines.svh]
// assertion macros for the matrix vector transform core
`ifndef MATRIX4X4_VECTOR_TRANSFORM_CORE_DEFINES_SVH
`define MATRIX4X4_VECTOR_TRANSFORM_CORE_DEFINES_SVH
`ifndef SYNTH
// check on every edge outside reset
`define MVT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);
// check on every edge, reset included
`define MVT_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) (prop)) else $error(msg);
`else
`define MVT_ASSERT(lbl, prop, msg)
`define MVT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[rtl/mvt_pkg.sv]
// shared types and constants of the matrix vector transform core
package mvt_pkg;

   localparam int DATA_W    = 32;
   localparam int PROD_W    = 2 * DATA_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int N_LANES   = 4;
   localparam int N_REGS    = 8;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_W     = 64;
   localparam int REG_SEL_W = 3;

   // register indexes
   localparam logic [REG_SEL_W-1:0] CSR_ROW0_COLS01 = 3'd0;
   localparam logic [REG_SEL_W-1:0] CSR_ROW0_COLS23 = 3'd1;
   localparam logic [REG_SEL_W-1:0] CSR_ROW1_COLS01 = 3'd2;
   localparam logic [REG_SEL_W-1:0] CSR_ROW1_COLS23 = 3'd3;
   localparam logic [REG_SEL_W-1:0] CSR_ROW2_COLS01 = 3'd4;
   localparam logic [REG_SEL_W-1:0] CSR_ROW2_COLS23 = 3'd5;
   localparam logic [REG_SEL_W-1:0] CSR_ROW3_COLS01 = 3'd6;
   localparam logic [REG_SEL_W-1:0] CSR_ROW3_COLS23 = 3'd7;

   localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   // four q16.16 words: one matrix row or the input vector
   typedef logic [N_LANES-1:0][DATA_W-1:0] quad_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              ovf;
   } lane_result_type;

   typedef lane_result_type [N_LANES-1:0] lane_results_type;

endpackage

[rtl/mvt_lane.sv]
// one row lane: four products, wide sum, shift and saturate
module mvt_lane
   import mvt_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic            clock,
   input  logic            advance,
   input  quad_type        row_i,
   input  quad_type        vec_i,
   output lane_result_type result_o
);

   logic signed [PROD_W-1:0] prod_in [N_LANES];
   logic signed [PROD_W-1:0] prod_ff [N_LANES];
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SUM_W-1:0]  sum_ff;
   logic signed [SUM_W-1:0]  shifted;
   logic [SUM_W-DATA_W:0]    upper;
   logic                     fits;

   always_comb begin
      for (int k = 0; k < N_LANES; k++) begin
         prod_in[k] = $signed(row_i[k]) * $signed(vec_i[k]);
      end
   end

   always_comb begin
      sum_in = '0;
      for (int k = 0; k < N_LANES; k++) begin
         sum_in = sum_in + $signed({{(SUM_W-PROD_W){prod_ff[k][PROD_W-1]}}, prod_ff[k]});
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < N_LANES; k++) begin
            prod_ff[k] <= prod_in[k];
         end
         sum_ff <= sum_in;
      end
   end

   // floor shift, then the top bits must all copy the result sign
   always_comb begin
      shifted = sum_ff >>> FRAC_BITS;
      upper   = shifted[SUM_W-1:DATA_W-1];
      fits    = (&upper) | ~(|upper);
      if (fits) begin
         result_o.value = shifted[DATA_W-1:0];
         result_o.ovf   = 1'b0;
      end else begin
         result_o.value = sum_ff[SUM_W-1] ? SAT_MIN : SAT_MAX;
         result_o.ovf   = 1'b1;
      end
   end

endmodule

[rtl/mvt_merge.sv]
// merge stage: registers the lane results and combines overflow
module mvt_merge
   import mvt_pkg::*;
(
   input  logic             clock,
   input  logic             advance,
   input  lane_results_type lanes_i,
   output quad_type         value_o,
   output logic             overflow_o
);

   quad_type value_in;
   quad_type value_ff;
   logic     overflow_in;
   logic     overflow_ff;

   always_comb begin
      overflow_in = 1'b0;
      for (int r = 0; r < N_LANES; r++) begin
         value_in[r] = lanes_i[r].value;
         overflow_in = overflow_in | lanes_i[r].ovf;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         value_ff    <= value_in;
         overflow_ff <= overflow_in;
      end
   end

   assign value_o    = value_ff;
   assign overflow_o = overflow_ff;

endmodule

[rtl/matrix4x4_vector_transform_core.sv]
// top level of the 4x4 matrix times vector transform core
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_stall  | req_in_x/y/z/w, q16.16
//  rsp     | out       | rsp_valid/rsp_stall  | rsp_out_x/y/z/w, rsp_overflow
//  csr     | in        | csr_write            | csr_index, csr_wdata (64 bits)
//
// one item per cycle while no result is held up; an item passes the product
//   register, sum register and output register in the merge stage
// the sixteen 32x32 multipliers of the four lanes set the pace
// reset loads the identity matrix and empties the pipeline
// a stalled result freezes the whole pipeline and raises req_stall
`include "matrix4x4_vector_transform_core_defines.svh"

module matrix4x4_vector_transform_core
   import mvt_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   // input items
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic [DATA_W-1:0]    req_in_x,
   input  logic [DATA_W-1:0]    req_in_y,
   input  logic [DATA_W-1:0]    req_in_z,
   input  logic [DATA_W-1:0]    req_in_w,
   // result items
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [DATA_W-1:0]    rsp_out_x,
   output logic [DATA_W-1:0]    rsp_out_y,
   output logic [DATA_W-1:0]    rsp_out_z,
   output logic [DATA_W-1:0]    rsp_out_w,
   output logic                 rsp_overflow,
   // configuration writes
   input  logic                 csr_write,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_W-1:0]     csr_wdata
);

   // one in q16.16 at this fraction width, placed low or high in a register
   localparam logic [CSR_W-1:0] ONE_LO = CSR_W'(1) << FRAC_BITS;
   localparam logic [CSR_W-1:0] ONE_HI = CSR_W'(1) << (DATA_W + FRAC_BITS);

   logic [CSR_W-1:0] cfg_in [N_REGS];
   logic [CSR_W-1:0] cfg_ff [N_REGS];

   logic             advance;
   logic             stage1_valid_in;
   logic             stage1_valid_ff;
   logic             stage2_valid_in;
   logic             stage2_valid_ff;
   logic             rsp_valid_in;
   logic             rsp_valid_ff;

   quad_type         vec;
   quad_type         rows [N_LANES];
   lane_results_type lane_res;
   quad_type         merged;

   // ---------------- configuration registers ----------------
   // writes beyond the last register are dropped
   always_comb begin
      for (int i = 0; i < N_REGS; i++) begin
         cfg_in[i] = cfg_ff[i];
      end
      if (csr_write && (csr_index < CSR_IDX_W'(N_REGS))) begin
         cfg_in[csr_index[REG_SEL_W-1:0]] = csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < N_REGS; i++) begin
            cfg_ff[i] <= '0;
         end
         cfg_ff[CSR_ROW0_COLS01] <= ONE_LO;
         cfg_ff[CSR_ROW1_COLS01] <= ONE_HI;
         cfg_ff[CSR_ROW2_COLS23] <= ONE_LO;
         cfg_ff[CSR_ROW3_COLS23] <= ONE_HI;
      end else begin
         for (int i = 0; i < N_REGS; i++) begin
            cfg_ff[i] <= cfg_in[i];
         end
      end
   end

   // unpack the row entries: column 0/2 in the low half, 1/3 in the high half
   always_comb begin
      for (int r = 0; r < N_LANES; r++) begin
         rows[r][0] = cfg_ff[2*r][DATA_W-1:0];
         rows[r][1] = cfg_ff[2*r][CSR_W-1:DATA_W];
         rows[r][2] = cfg_ff[2*r+1][DATA_W-1:0];
         rows[r][3] = cfg_ff[2*r+1][CSR_W-1:DATA_W];
      end
   end

   // ---------------- pipeline control ----------------
   // the pipe moves unless a finished result is held up
   assign advance   = ~(rsp_valid_ff & rsp_stall);
   assign req_stall = ~advance;

   assign stage1_valid_in = advance ? req_valid       : stage1_valid_ff;
   assign stage2_valid_in = advance ? stage1_valid_ff : stage2_valid_ff;
   assign rsp_valid_in    = advance ? stage2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_valid_ff <= 1'b0;
         stage2_valid_ff <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         stage1_valid_ff <= stage1_valid_in;
         stage2_valid_ff <= stage2_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // ---------------- row lanes ----------------
   assign vec[0] = req_in_x;
   assign vec[1] = req_in_y;
   assign vec[2] = req_in_z;
   assign vec[3] = req_in_w;

   for (genvar r = 0; r < N_LANES; r++) begin : g_lane
      mvt_lane #(
         .FRAC_BITS (FRAC_BITS)
      ) u_lane (
         .clock    (clock),
         .advance  (advance),
         .row_i    (rows[r]),
         .vec_i    (vec),
         .result_o (lane_res[r])
      );
   end

   // ---------------- merge and output register ----------------
   mvt_merge u_merge (
      .clock      (clock),
      .advance    (advance),
      .lanes_i    (lane_res),
      .value_o    (merged),
      .overflow_o (rsp_overflow)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = merged[0];
   assign rsp_out_y = merged[1];
   assign rsp_out_z = merged[2];
   assign rsp_out_w = merged[3];

   // ---------------- checks ----------------
   `MVT_ASSERT(a_accept_enters_pipe, (req_valid && !req_stall) |=> stage1_valid_ff, "accepted item lost at stage 1")
   `MVT_ASSERT(a_stage2_reaches_out, (stage2_valid_ff && advance) |=> rsp_valid_ff, "item lost before the output register")
   `MVT_ASSERT_ALWAYS(a_held_result_stalls_input, (rsp_valid_ff && rsp_stall) |-> req_stall, "input taken while a result is held")
   `MVT_ASSERT(a_overflow_means_saturated, (rsp_valid_ff && rsp_overflow) |-> (rsp_out_x == SAT_MAX || rsp_out_x == SAT_MIN || rsp_out_y == SAT_MAX || rsp_out_y == SAT_MIN || rsp_out_z == SAT_MAX || rsp_out_z == SAT_MIN || rsp_out_w == SAT_MAX || rsp_out_w == SAT_MIN), "overflow flag without a saturated component")

endmodule
